[rtl/core/jaam_pkg.sv]
// Shared widths, codes and types for the joystick axis calibration mapper.
package jaam_pkg;

  // Raw converter resolution and number of calibrated axes.
  localparam int ADC_BITS = 10;
  localparam int AXES     = 2;
  localparam int AXIS_W   = (AXES > 1) ? $clog2(AXES) : 1;

  // Field widths on the stream ports.
  localparam int SAMPLE_W   = ADC_BITS;
  localparam int S_TDATA_W  = ((SAMPLE_W + 7) / 8) * 8;
  localparam int S_TUSER_W  = 1 + AXIS_W;
  localparam int POS_W      = 8;
  localparam int M_TDATA_W  = 8;

  // Signed running min/max must also hold the reset values of +/-1000.
  localparam int RANGE_W  = ((ADC_BITS > 10) ? ADC_BITS : 10) + 2;
  localparam int CENTER_W = ADC_BITS + 1;

  // Divider: span and numerator fit in SAMPLE_W bits, the scaled
  // numerator is num * 127, and the quotient never exceeds 127.
  localparam int Q_W    = 7;
  localparam int DIVD_W = SAMPLE_W + Q_W;
  localparam int CNT_W  = $clog2(Q_W);

  localparam logic signed [RANGE_W-1:0] LOW_RESET  = RANGE_W'(1000);
  localparam logic signed [RANGE_W-1:0] HIGH_RESET = -RANGE_W'(1000);
  localparam logic [POS_W-1:0] UPPER_BASE      = POS_W'(128);
  localparam logic [POS_W-1:0] ZERO_SPAN_VALUE = POS_W'(127);

  // Request opcodes.
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_CENTER = 1'b1;

  // Status of the shared divider as seen by the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

[rtl/core/joystick_axis_autocal_map_top.sv]
// Top level of the joystick axis calibration mapper: sequencer and per-axis state.
//
// Usage: requests enter on the s_axis channel. tuser[0] is the opcode (sample or
// capture center) and tuser[1] selects the axis; tdata holds the raw converter
// reading. Every accepted sample request widens that axis's running minimum and
// maximum and yields one result on m_axis: tuser[0] is the axis, tdata the mapped
// byte (0..127 below center, 128..255 at or above). A capture request stores the
// reading as the axis center, widens the range and yields nothing.
// One request is handled at a time; s_axis_tready is high only while idle.
// A capture widens the range, stores the center and returns to idle. A sample
// widens the range, forms numerator and span, runs the shared one-bit-per-cycle
// divider and registers the result; the next request is taken only after that
// result has left on m_axis. A zero span skips the divider and returns 127.
// While m_axis_tvalid is high and m_axis_tready is low the result is held and no
// new request is taken. Reset clears the range to min 1000 / max -1000 and the
// center to zero for every axis and leaves the block idle.
module joystick_axis_autocal_map_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [jaam_pkg::S_TDATA_W-1:0]    s_axis_tdata,  // [9:0] sample
  input  logic [jaam_pkg::S_TUSER_W-1:0]    s_axis_tuser,  // [0] opcode, [1] axis_select
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [jaam_pkg::M_TDATA_W-1:0]    m_axis_tdata,  // [7:0] position
  output logic [jaam_pkg::AXIS_W-1:0]       m_axis_tuser   // [0] axis_out
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_WIDEN = 5'b00010,
    ST_PREP  = 5'b00100,
    ST_DIV   = 5'b01000,
    ST_OUT   = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // Latched request.
  logic                              op_q;
  logic [jaam_pkg::AXIS_W-1:0]       axis_q;
  logic [jaam_pkg::SAMPLE_W-1:0]     smp_q;

  // Per-axis calibration state.
  logic signed [jaam_pkg::RANGE_W-1:0] low_q    [jaam_pkg::AXES];
  logic signed [jaam_pkg::RANGE_W-1:0] high_q   [jaam_pkg::AXES];
  logic [jaam_pkg::CENTER_W-1:0]       center_q [jaam_pkg::AXES];

  // Result registers.
  logic                              lower_q;
  logic [jaam_pkg::POS_W-1:0]        pos_q;

  logic                                s_acc;
  logic                                axis_ok;
  logic signed [jaam_pkg::RANGE_W-1:0] s_ext;
  logic signed [jaam_pkg::RANGE_W-1:0] c_ext;
  logic signed [jaam_pkg::RANGE_W-1:0] num_w;
  logic signed [jaam_pkg::RANGE_W-1:0] span_w;
  logic                                is_lower;
  logic [jaam_pkg::SAMPLE_W-1:0]       num;
  logic [jaam_pkg::SAMPLE_W-1:0]       span;
  logic [jaam_pkg::DIVD_W-1:0]         dividend;
  logic                                div_start;
  logic [jaam_pkg::Q_W-1:0]            quot;
  jaam_pkg::div_status_t               div_st;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign axis_ok       = (int'(axis_q) < jaam_pkg::AXES);

  // Sample and center of the selected axis as signed values of the range width.
  assign s_ext = $signed(jaam_pkg::RANGE_W'(smp_q));
  assign c_ext = $signed(jaam_pkg::RANGE_W'(center_q[axis_q]));

  // After widening, min <= sample <= max, so numerator and span are both
  // nonnegative and fit in the sample width.
  always_comb begin
    is_lower = (s_ext < c_ext);
    if (is_lower) begin
      num_w  = s_ext - low_q[axis_q];
      span_w = c_ext - low_q[axis_q];
    end else begin
      num_w  = s_ext - c_ext;
      span_w = high_q[axis_q] - c_ext;
    end
    num      = num_w[jaam_pkg::SAMPLE_W-1:0];
    span     = span_w[jaam_pkg::SAMPLE_W-1:0];
    // num * 127 as a shift and one subtract.
    dividend = (jaam_pkg::DIVD_W'(num) << jaam_pkg::Q_W) - jaam_pkg::DIVD_W'(num);
  end

  assign div_start = (state_q == ST_PREP) && (span != '0);

  jaam_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (span),
    .quot_o     (quot),
    .status_o   (div_st)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (s_acc) state_d = ST_WIDEN;
      end
      ST_WIDEN: begin
        if (!axis_ok || (op_q == jaam_pkg::OP_CENTER)) state_d = ST_IDLE;
        else                                          state_d = ST_PREP;
      end
      ST_PREP: begin
        if (span == '0) state_d = ST_OUT;
        else            state_d = ST_DIV;
      end
      ST_DIV: begin
        if (div_st.done) state_d = ST_OUT;
      end
      ST_OUT: begin
        if (m_axis_tready) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Calibration state: widened on every request, center written on capture.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < jaam_pkg::AXES; a++) begin
        low_q[a]    <= jaam_pkg::LOW_RESET;
        high_q[a]   <= jaam_pkg::HIGH_RESET;
        center_q[a] <= '0;
      end
    end else if ((state_q == ST_WIDEN) && axis_ok) begin
      if (s_ext > high_q[axis_q]) high_q[axis_q] <= s_ext;
      if (s_ext < low_q[axis_q])  low_q[axis_q]  <= s_ext;
      if (op_q == jaam_pkg::OP_CENTER) begin
        center_q[axis_q] <= jaam_pkg::CENTER_W'(smp_q);
      end
    end
  end

  // Request and result payload.
  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      op_q   <= s_axis_tuser[0];
      axis_q <= s_axis_tuser[jaam_pkg::AXIS_W:1];
      smp_q  <= s_axis_tdata[jaam_pkg::SAMPLE_W-1:0];
    end
    if (state_q == ST_PREP) begin
      lower_q <= is_lower;
      if (span == '0) pos_q <= jaam_pkg::ZERO_SPAN_VALUE;
    end
    if ((state_q == ST_DIV) && div_st.done) begin
      if (lower_q) pos_q <= jaam_pkg::POS_W'(quot);
      else         pos_q <= jaam_pkg::UPPER_BASE + jaam_pkg::POS_W'(quot);
    end
  end

  assign m_axis_tvalid = (state_q == ST_OUT);
  assign m_axis_tdata  = pos_q;
  assign m_axis_tuser  = axis_q;

  // A pending result blocks new requests.
  a_out_blocks_in : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("request taken while a result is pending");

  // The divider only runs while the sequencer waits for it.
  a_div_in_div_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_st.busy |-> (state_q == ST_DIV))
    else $error("divider busy outside the divide state");

  // An accepted request always goes to the widening step next.
  a_accept_widens : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> (state_q == ST_WIDEN))
    else $error("accepted request did not start widening");

endmodule

[rtl/core/jaam_div.sv]
// Restoring divider that produces one quotient bit per cycle.
module jaam_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [jaam_pkg::DIVD_W-1:0]     dividend_i,
  input  logic [jaam_pkg::SAMPLE_W-1:0]   divisor_i,
  output logic [jaam_pkg::Q_W-1:0]        quot_o,
  output jaam_pkg::div_status_t           status_o
);

  logic [jaam_pkg::DIVD_W-1:0] rem_q;
  logic [jaam_pkg::DIVD_W-1:0] dsr_q;
  logic [jaam_pkg::Q_W-1:0]    quot_q;
  logic [jaam_pkg::CNT_W-1:0]  cnt_q;
  logic                        busy_q;
  logic                        done_q;
  logic                        fits;

  // The shifted divisor walks down one bit per step; the quotient is
  // known to stay below 2**Q_W, so the first step starts at Q_W-1.
  assign fits = (rem_q >= dsr_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= jaam_pkg::CNT_W'(jaam_pkg::Q_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= dividend_i;
      dsr_q  <= jaam_pkg::DIVD_W'(divisor_i) << (jaam_pkg::Q_W - 1);
      quot_q <= '0;
    end else if (busy_q) begin
      if (fits) begin
        rem_q <= rem_q - dsr_q;
      end
      quot_q <= {quot_q[jaam_pkg::Q_W-2:0], fits};
      dsr_q  <= dsr_q >> 1;
    end
  end

  assign quot_o          = quot_q;
  assign status_o.busy   = busy_q;
  assign status_o.done   = done_q;

endmodule
